// ===== rtl/core/lcfd_pkg.sv =====
package lcfd_pkg;

   localparam int PAYLOAD_DEPTH = 32;
   localparam int POS_W = $clog2(PAYLOAD_DEPTH + 4);
   localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   localparam logic [7:0] HDR_SYNC  = 8'h55;
   localparam logic [7:0] HDR_ADDR  = 8'h01;
   localparam logic [7:0] CH_END    = 8'h23;
   localparam logic [7:0] CH_UPDATE = 8'h75;
   localparam logic [7:0] CH_GET    = 8'h67;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   typedef enum logic [2:0] {
      KIND_DATA  = 3'd0,
      KIND_FIELD = 3'd1,
      KIND_CSUM  = 3'd2,
      KIND_GET   = 3'd3,
      KIND_OVF   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      SEL_OVF,
      SEL_CSUM,
      SEL_GET,
      SEL_REPLAY
   } out_sel_type;

   typedef struct packed {
      logic        take_byte;
      logic        clear;
      logic        out_load;
      out_sel_type sel;
      logic        idx_next;
   } cmd_type;

   typedef struct packed {
      logic is_end;
      logic frame_ok;
      logic ovf;
      logic cmd_u;
      logic cmd_g;
      logic csum_bad;
      logic out_last;
   } status_type;

endpackage

// ===== rtl/core/lrc_checked_frame_deframer.sv =====
// Frame deframer with LRC check for a byte stream from a serial receiver.
// Input channel req_: one received byte per word on req_rx_byte. Bytes are
// gathered until '#'; a frame must open 0x55 0x01, then a command byte.
// Output channel rsp_: kind / value / last per word. Command 'u' replays
// the payload (data bytes, field ends at commas, a closing field end) when
// the check byte makes the 8-bit sum zero, else one checksum error. Command
// 'g' returns the byte after the command, or '#' when there is none. An
// overrun of the payload store gives one overflow word. Bad headers and
// other commands give nothing. Throughput: a non-terminator byte is taken
// every cycle while req_stall is low. The '#' word is evaluated in ST_EVAL,
// which loads the first result; each later replayed result needs a store
// read address step, a registered read and an output load, and a result
// waits while rsp_stall is high. req_stall is high from the '#' until the
// last result of the frame is taken; while the receiver stalls, the
// result word holds steady. Reset (synchronous, active high) clears frame
// state and drops any pending result; the payload store is not cleared.
module lrc_checked_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic       rsp_last
);

   lcfd_pkg::cmd_type    cmd;
   lcfd_pkg::status_type status;

   lcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lcfd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_rx_byte),
      .cmd       (cmd),
      .status    (status),
      .out_kind  (rsp_kind),
      .out_value (rsp_value),
      .out_last  (rsp_last)
   );

endmodule

// ===== rtl/core/lcfd_dp.sv =====
module lcfd_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_byte,
   input  lcfd_pkg::cmd_type    cmd,
   output lcfd_pkg::status_type status,
   output logic [2:0]           out_kind,
   output logic [7:0]           out_value,
   output logic                 out_last
);

   logic [lcfd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                        hdr_ff, hdr_in;
   logic [7:0]                  cmd_ff, cmd_in;
   logic [7:0]                  sum_ff, sum_in;
   logic                        ovf_ff, ovf_in;
   logic [lcfd_pkg::POS_W-1:0] idx_ff, idx_in;
   logic [7:0]                  rd_data_ff;
   logic [7:0]                  mem [lcfd_pkg::PAYLOAD_DEPTH];
   logic [2:0]                  kind_ff, kind_in;
   logic [7:0]                  value_ff, value_in;
   logic                        last_ff, last_in;

   logic [lcfd_pkg::POS_W-1:0] stored;
   logic                        wr_en;
   logic                        more;

   localparam logic [lcfd_pkg::POS_W-1:0] HDR_LEN = lcfd_pkg::POS_W'(3);
   localparam logic [lcfd_pkg::POS_W-1:0] DEPTH_P = lcfd_pkg::POS_W'(lcfd_pkg::PAYLOAD_DEPTH);
   localparam logic [lcfd_pkg::POS_W-1:0] ONE_P   = lcfd_pkg::POS_W'(1);

   assign stored = pos_ff - HDR_LEN;
   assign more   = (idx_ff + ONE_P) < stored;

   always_comb begin
      pos_in = pos_ff;
      hdr_in = hdr_ff;
      cmd_in = cmd_ff;
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      wr_en  = 1'b0;
      if (cmd.take_byte) begin
         case (pos_ff)
            lcfd_pkg::POS_W'(0): begin
               hdr_in = (rx_byte == lcfd_pkg::HDR_SYNC);
               pos_in = lcfd_pkg::POS_W'(1);
            end
            lcfd_pkg::POS_W'(1): begin
               hdr_in = hdr_ff && (rx_byte == lcfd_pkg::HDR_ADDR);
               pos_in = lcfd_pkg::POS_W'(2);
            end
            lcfd_pkg::POS_W'(2): begin
               cmd_in = rx_byte;
               pos_in = HDR_LEN;
            end
            default: begin
               if (stored < DEPTH_P) begin
                  wr_en  = 1'b1;
                  sum_in = sum_ff + rx_byte;
                  pos_in = pos_ff + ONE_P;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_next) begin
         idx_in = idx_ff + ONE_P;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff <= '0;
         hdr_ff <= 1'b0;
         cmd_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         hdr_ff <= hdr_in;
         cmd_ff <= cmd_in;
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[stored[lcfd_pkg::ADDR_W-1:0]] <= rx_byte;
      end
      rd_data_ff <= mem[idx_ff[lcfd_pkg::ADDR_W-1:0]];
   end

   always_comb begin
      kind_in  = kind_ff;
      value_in = value_ff;
      last_in  = last_ff;
      case (cmd.sel)
         lcfd_pkg::SEL_OVF: begin
            kind_in  = lcfd_pkg::KIND_OVF;
            value_in = '0;
            last_in  = 1'b1;
         end
         lcfd_pkg::SEL_CSUM: begin
            kind_in  = lcfd_pkg::KIND_CSUM;
            value_in = '0;
            last_in  = 1'b1;
         end
         lcfd_pkg::SEL_GET: begin
            kind_in  = lcfd_pkg::KIND_GET;
            value_in = (stored != '0) ? rd_data_ff : lcfd_pkg::CH_END;
            last_in  = 1'b1;
         end
         lcfd_pkg::SEL_REPLAY: begin
            if (!more) begin
               kind_in  = lcfd_pkg::KIND_FIELD;
               value_in = '0;
               last_in  = 1'b1;
            end else if (rd_data_ff == lcfd_pkg::CH_COMMA) begin
               kind_in  = lcfd_pkg::KIND_FIELD;
               value_in = '0;
               last_in  = 1'b0;
            end else begin
               kind_in  = lcfd_pkg::KIND_DATA;
               value_in = rd_data_ff;
               last_in  = 1'b0;
            end
         end
         default: begin
            kind_in  = lcfd_pkg::KIND_OVF;
            value_in = '0;
            last_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign status.is_end   = (rx_byte == lcfd_pkg::CH_END);
   assign status.frame_ok = (pos_ff >= HDR_LEN) && hdr_ff;
   assign status.ovf      = ovf_ff;
   assign status.cmd_u    = (cmd_ff == lcfd_pkg::CH_UPDATE);
   assign status.cmd_g    = (cmd_ff == lcfd_pkg::CH_GET);
   assign status.csum_bad = (stored == '0) || (sum_ff != '0);
   assign status.out_last = last_ff;

   assign out_kind  = kind_ff;
   assign out_value = value_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/core/lcfd_ctrl.sv =====
module lcfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lcfd_pkg::status_type status,
   output lcfd_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SEND,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      rsp_take;

   assign rsp_take = valid_ff && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd      = '{take_byte: 1'b0, clear: 1'b0, out_load: 1'b0,
                   sel: lcfd_pkg::SEL_REPLAY, idx_next: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.is_end) begin
                  state_in = ST_EVAL;
               end else begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         ST_EVAL: begin
            if (!status.frame_ok) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.ovf) begin
               cmd.out_load = 1'b1;
               cmd.sel      = lcfd_pkg::SEL_OVF;
            end else if (status.cmd_u) begin
               cmd.out_load = 1'b1;
               cmd.sel      = status.csum_bad ? lcfd_pkg::SEL_CSUM : lcfd_pkg::SEL_REPLAY;
            end else if (status.cmd_g) begin
               cmd.out_load = 1'b1;
               cmd.sel      = lcfd_pkg::SEL_GET;
            end else begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
            if (cmd.out_load) begin
               valid_in = 1'b1;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_take) begin
               valid_in = 1'b0;
               if (status.out_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.idx_next = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.sel      = lcfd_pkg::SEL_REPLAY;
            valid_in     = 1'b1;
            state_in     = ST_SEND;
         end
         default: begin
            cmd.clear = 1'b1;
            valid_in  = 1'b0;
            state_in  = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ===== rtl/core/lcfd_checker.sv =====
module lcfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_value,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value)
         && $stable(rsp_last))
      else $error("stalled result word changed");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= lcfd_pkg::KIND_OVF)
      else $error("result kind out of range");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != lcfd_pkg::KIND_DATA && rsp_kind != lcfd_pkg::KIND_GET
         |-> rsp_value == 8'h00)
      else $error("nonzero value on a mark word");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == lcfd_pkg::KIND_OVF || rsp_kind == lcfd_pkg::KIND_CSUM
         || rsp_kind == lcfd_pkg::KIND_GET) |-> rsp_last)
      else $error("single-word result without last");

endmodule

bind lrc_checked_frame_deframer lcfd_checker u_lcfd_checker (.*);

// ===== tb/lrc_checked_frame_deframer_tb.sv =====
`timescale 1ns / 100ps

module lrc_checked_frame_deframer_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int LRC_NONE = 0;
   localparam int LRC_GOOD = 1;
   localparam int LRC_BAD  = 2;
   localparam logic [7:0] CH_OTHER = 8'h78;

   typedef struct packed {
      lcfd_pkg::kind_type kind;
      logic [7:0]         value;
      logic               last;
   } result_word_type;

   // Tracks frame state from accepted bytes; holds the words each '#' must produce.
   class frame_board_type;
      int              frame_len;
      bit              sync_ok;
      logic [7:0]      command;
      logic [7:0]      lrc_sum;
      bit              overrun;
      logic [7:0]      payload[lcfd_pkg::PAYLOAD_DEPTH];
      result_word_type expected_words[$];
      int              errors;

      function new();
         clear_frame();
         errors = 0;
      endfunction

      function void clear_frame();
         frame_len = 0;
         sync_ok = 0;
         command = 0;
         lrc_sum = 0;
         overrun = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void take_byte(logic [7:0] b);
         int stored;
         if (b != lcfd_pkg::CH_END) begin
            if (frame_len == 0) begin
               sync_ok = (b == lcfd_pkg::HDR_SYNC);
               frame_len = 1;
            end else if (frame_len == 1) begin
               sync_ok = sync_ok && (b == lcfd_pkg::HDR_ADDR);
               frame_len = 2;
            end else if (frame_len == 2) begin
               command = b;
               frame_len = 3;
            end else if (frame_len - 3 < lcfd_pkg::PAYLOAD_DEPTH) begin
               payload[frame_len - 3] = b;
               lrc_sum = lrc_sum + b;
               frame_len++;
            end else begin
               overrun = 1;
            end
            return;
         end
         if (frame_len >= 3 && sync_ok) begin
            stored = frame_len - 3;
            if (overrun) begin
               expected_words.push_back('{lcfd_pkg::KIND_OVF, 8'd0, 1'b1});
            end else if (command == lcfd_pkg::CH_UPDATE) begin
               if (stored == 0 || lrc_sum != 0) begin
                  expected_words.push_back('{lcfd_pkg::KIND_CSUM, 8'd0, 1'b1});
               end else begin
                  for (int i = 0; i + 1 < stored; i++) begin
                     if (payload[i] == lcfd_pkg::CH_COMMA)
                        expected_words.push_back('{lcfd_pkg::KIND_FIELD, 8'd0, 1'b0});
                     else
                        expected_words.push_back('{lcfd_pkg::KIND_DATA, payload[i], 1'b0});
                  end
                  expected_words.push_back('{lcfd_pkg::KIND_FIELD, 8'd0, 1'b1});
               end
            end else if (command == lcfd_pkg::CH_GET) begin
               expected_words.push_back('{lcfd_pkg::KIND_GET,
                                          (stored >= 1) ? payload[0] : lcfd_pkg::CH_END,
                                          1'b1});
            end
         end
         clear_frame();
      endfunction

      function void check_word(logic [2:0] kind, logic [7:0] value, logic last);
         result_word_type exp_w;
         if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d value 0x%02h last %0d", kind, value, last);
            errors++;
            return;
         end
         exp_w = expected_words.pop_front();
         if (kind !== exp_w.kind) begin
            $error("kind: expected %0d, actual %0d", exp_w.kind, kind);
            errors++;
         end
         if (value !== exp_w.value) begin
            $error("value: expected 0x%02h, actual 0x%02h", exp_w.value, value);
            errors++;
         end
         if (last !== exp_w.last) begin
            $error("last: expected %0d, actual %0d", exp_w.last, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_value;
   logic       rsp_last;

   frame_board_type board;
   logic [7:0]      burst[$];
   int              items_sent;
   int              cycles;
   bit              quiet;
   bit              want_hold;

   lrc_checked_frame_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[lrc_checked_frame_deframer] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_kind, rsp_value, rsp_last);
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int hold_count;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (want_hold) begin
            rsp_stall = 1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
               @(negedge clock);
            want_hold = 0;
         end
         rsp_stall = !quiet && ($urandom_range(99) < 27);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      req_rx_byte = b;
      req_valid = 1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.take_byte(b);
      items_sent++;
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 27) begin
         req_valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic send_burst();
      while (burst.size() != 0)
         send_byte(burst.pop_front());
   endtask

   task automatic add_frame(input logic [7:0] cmd, input int n, input int lrc_mode);
      logic [7:0] b;
      logic [7:0] sum;
      sum = 0;
      burst.push_back(lcfd_pkg::HDR_SYNC);
      burst.push_back(lcfd_pkg::HDR_ADDR);
      burst.push_back(cmd);
      for (int i = 0; i < n; i++) begin
         b = ($urandom_range(99) < 15) ? lcfd_pkg::CH_COMMA : 8'($urandom_range(255));
         if (b == lcfd_pkg::CH_END)
            b = 8'h24;
         burst.push_back(b);
         sum = sum + b;
      end
      if (lrc_mode == LRC_GOOD)
         burst.push_back(~sum + 8'd1);
      else if (lrc_mode == LRC_BAD)
         burst.push_back(~sum + 8'd1 + 8'($urandom_range(1, 255)));
      burst.push_back(lcfd_pkg::CH_END);
   endtask

   initial begin
      int  base;
      int  r;
      int  len;
      bit  hold_done;
      bit  pause_done;
      board = new();
      reset = 1;
      req_valid = 0;
      req_rx_byte = 0;
      quiet = 0;
      want_hold = 0;
      items_sent = 0;
      hold_done = 0;
      pause_done = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // short frames: '#' inside header or command
      burst = '{lcfd_pkg::CH_END, lcfd_pkg::HDR_SYNC, lcfd_pkg::CH_END,
                lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_END};
      send_burst();
      // good update with commas, 0x00 and 0xFF
      burst = '{lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_UPDATE, 8'h00, 8'hFF,
                lcfd_pkg::CH_COMMA, lcfd_pkg::CH_COMMA, 8'h41, 8'h68, lcfd_pkg::CH_END};
      send_burst();
      // bad check, no check byte, check byte only
      burst = '{lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_UPDATE, 8'h01, 8'h02,
                8'h00, lcfd_pkg::CH_END,
                lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_UPDATE, lcfd_pkg::CH_END,
                lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_UPDATE, 8'h00,
                lcfd_pkg::CH_END};
      send_burst();
      // get-back with and without a byte
      burst = '{lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_GET, 8'hFF, 8'h12,
                lcfd_pkg::CH_END,
                lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_GET, lcfd_pkg::CH_END};
      send_burst();
      // bad headers and an unknown command
      burst = '{8'h54, lcfd_pkg::HDR_ADDR, lcfd_pkg::CH_UPDATE, 8'h00, lcfd_pkg::CH_END,
                lcfd_pkg::HDR_SYNC, 8'h02, lcfd_pkg::CH_GET, 8'h11, lcfd_pkg::CH_END,
                lcfd_pkg::HDR_SYNC, lcfd_pkg::HDR_ADDR, CH_OTHER, 8'h11, lcfd_pkg::CH_END};
      send_burst();
      // full store, then overruns on both commands
      add_frame(lcfd_pkg::CH_UPDATE, lcfd_pkg::PAYLOAD_DEPTH - 1, LRC_GOOD);
      add_frame(lcfd_pkg::CH_UPDATE, lcfd_pkg::PAYLOAD_DEPTH, LRC_GOOD);
      add_frame(lcfd_pkg::CH_GET, lcfd_pkg::PAYLOAD_DEPTH + 2, LRC_NONE);
      send_burst();

      base = items_sent;
      while (items_sent < base + 140) begin
         quiet = (items_sent >= base + 70) && (items_sent < base + 110);
         if (!hold_done && items_sent >= base + 30) begin
            want_hold = 1;
            hold_done = 1;
         end
         if (!pause_done && items_sent >= base + 115) begin
            req_valid = 0;
            while (board.pending() != 0)
               @(negedge clock);
            pause_done = 1;
         end
         r = $urandom_range(99);
         if (r < 45) begin
            if ($urandom_range(14) == 0)
               len = $urandom_range(25, lcfd_pkg::PAYLOAD_DEPTH - 1);
            else
               len = $urandom_range(0, 8);
            add_frame(lcfd_pkg::CH_UPDATE, len, LRC_GOOD);
         end else if (r < 55)
            add_frame(lcfd_pkg::CH_UPDATE, $urandom_range(0, 8), LRC_BAD);
         else if (r < 65)
            add_frame(lcfd_pkg::CH_GET, $urandom_range(0, 3), LRC_NONE);
         else if (r < 68)
            add_frame(($urandom_range(1) == 0) ? lcfd_pkg::CH_UPDATE : lcfd_pkg::CH_GET,
                      $urandom_range(lcfd_pkg::PAYLOAD_DEPTH, lcfd_pkg::PAYLOAD_DEPTH + 3),
                      LRC_GOOD);
         else if (r < 75)
            add_frame(8'($urandom_range(255)), $urandom_range(0, 4), LRC_GOOD);
         else if (r < 85) begin
            add_frame(lcfd_pkg::CH_UPDATE, $urandom_range(0, 5), LRC_GOOD);
            if ($urandom_range(1) == 0)
               burst[0] = lcfd_pkg::HDR_SYNC ^ 8'($urandom_range(1, 255));
            else
               burst[1] = lcfd_pkg::HDR_ADDR ^ 8'($urandom_range(1, 255));
         end else begin
            repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(255)));
         end
         send_burst();
      end
      req_valid = 0;
      quiet = 0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("[lrc_checked_frame_deframer] OK");
      else
         $display("[lrc_checked_frame_deframer] ERROR");
      $finish;
   end

endmodule
